>>> sv/sea_block_cipher_defines.svh
// Assertion macros used by the block cipher controller.
`ifndef SEA_BLOCK_CIPHER_DEFINES_SVH
`define SEA_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sbc_pkg.sv
// Types, constants and the round mixing function of the block cipher.
`default_nettype none
package sbc_pkg;

  localparam int WORD_BITS    = 32;
  localparam int NUM_KEY_REGS = 6;
  localparam int CFG_IDX_W    = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [2:0][WORD_BITS-1:0] word3_t;
  typedef logic [5:0][WORD_BITS-1:0] word6_t;

  typedef struct packed {
    logic  kind;
    word_t block_word_0;
    word_t block_word_1;
    word_t block_word_2;
    word_t block_word_3;
    word_t block_word_4;
    word_t block_word_5;
  } sbc_in_t;

  typedef struct packed {
    word_t result_word_0;
    word_t result_word_1;
    word_t result_word_2;
    word_t result_word_3;
    word_t result_word_4;
    word_t result_word_5;
  } sbc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYGEN,
    ST_PREFETCH,
    ST_ROUND,
    ST_DONE
  } sbc_state_t;

  typedef struct packed {
    logic load;
    logic kinit;
    logic kaddr_first;
    logic kg_step;
    logic rd_step;
    logic round_en;
  } sbc_cmd_t;

  // Key addition, bitsliced S-box and the single-bit word rotations.
  function automatic word3_t sbc_mix(input word3_t x, input word3_t k);
    word_t  a;
    word_t  b;
    word_t  c;
    word3_t t;
    a = x[0] + k[0];
    b = x[1] + k[1];
    c = x[2] + k[2];
    a = a ^ (b & c);
    b = b ^ (a & c);
    c = c ^ (a | b);
    t[0] = {a[0], a[WORD_BITS-1:1]};
    t[1] = b;
    t[2] = {c[WORD_BITS-2:0], c[WORD_BITS-1]};
    return t;
  endfunction

endpackage
`default_nettype wire

>>> sv/sbc_ctrl.sv
// Controller state machine: key schedule pass, key prefetch, round loop, result strobe.
`default_nettype none
module sbc_ctrl
  import sbc_pkg::*;
#(
  parameter int ROUNDS = 51
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  output logic          out_valid,
  output sbc_cmd_t      cmd
);

  localparam int CW = $clog2(ROUNDS + 1);
  localparam logic [CW-1:0] RLAST = CW'(ROUNDS - 1);

  sbc_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          keys_ready_r, keys_ready_nxt;
  logic          accept;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign accept    = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = keys_ready_r ? ST_PREFETCH : ST_KEYGEN;
        end
      end
      ST_KEYGEN: begin
        if (cnt_r == RLAST) begin
          state_nxt = ST_PREFETCH;
        end
      end
      ST_PREFETCH: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (cnt_r == RLAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cnt_nxt        = cnt_r;
    keys_ready_nxt = keys_ready_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          cmd.load        = 1'b1;
          cmd.kinit       = !keys_ready_r;
          cmd.kaddr_first = keys_ready_r;
        end
      end
      ST_KEYGEN: begin
        cmd.kg_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == RLAST) begin
          cmd.kaddr_first = 1'b1;
          keys_ready_nxt  = 1'b1;
          cnt_nxt         = '0;
        end
      end
      ST_PREFETCH: begin
        cmd.rd_step = 1'b1;
        cnt_nxt     = '0;
      end
      ST_ROUND: begin
        cmd.rd_step  = 1'b1;
        cmd.round_en = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
      end
      ST_DONE: cnt_nxt = '0;
      default: cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_ready_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      keys_ready_r <= keys_ready_nxt;
    end
  end

`include "sea_block_cipher_defines.svh"

  `SBC_ASSERT_IMP(a_done_keys, out_valid, keys_ready_r, "result strobed without a key schedule")
  `SBC_ASSERT_NXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
  `SBC_ASSERT_NXT(a_done_idle, state_r == ST_DONE, state_r == ST_IDLE, "result held past one cycle")
  `SBC_ASSERT_IMP(a_keygen_once, state_r == ST_KEYGEN, !keys_ready_r, "key schedule rebuilt")

endmodule
`default_nettype wire

>>> sv/sbc_datapath.sv
// Datapath: key registers, key schedule step, round key memory and the round unit.
`default_nettype none
module sbc_datapath
  import sbc_pkg::*;
#(
  parameter int ROUNDS = 51
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire word_t                cfg_data,
  input  wire sbc_in_t              in_data,
  input  wire sbc_cmd_t             cmd,
  output sbc_out_t                  out_data
);

  localparam int CW = $clog2(ROUNDS + 1);
  localparam int AW = $clog2(ROUNDS);
  localparam logic [CW-1:0] HALF  = CW'((ROUNDS + 1) / 2);
  localparam logic [CW-1:0] RMAX  = CW'(ROUNDS);
  localparam logic [CW-1:0] RLAST = CW'(ROUNDS - 1);
  localparam logic [CFG_IDX_W-1:0] KEY_REG_CNT = CFG_IDX_W'(NUM_KEY_REGS);

  word6_t        key_reg_r;
  word6_t        ks_r, ks_nxt;
  word3_t        lo_r, lo_nxt;
  word3_t        hi_r, hi_nxt;
  logic          dec_r, dec_nxt;
  logic [CW-1:0] kaddr_r, kaddr_nxt;
  word3_t        key_mem [ROUNDS];
  word3_t        rd_data_r;
  word3_t        wr_half;
  logic [CW-1:0] kg_idx;
  logic [CW-1:0] kg_cst;
  word3_t        kg_t;
  word3_t        kg_lo;
  word3_t        kg_hi;
  word3_t        rt;
  word3_t        rn;
  logic          first_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_reg_r <= '0;
    end else if (cfg_we && (cfg_index < KEY_REG_CNT)) begin
      key_reg_r[cfg_index] <= cfg_data;
    end
  end

  // One step of the key schedule: round index kaddr + 1 from the state of round kaddr.
  always_comb begin
    kg_idx  = kaddr_r + 1'b1;
    kg_cst  = (kg_idx <= HALF) ? kg_idx : (RMAX - kg_idx);
    kg_t    = sbc_mix(ks_r[2:0], {word_t'(0), word_t'(0), WORD_BITS'(kg_cst)});
    kg_lo[0] = kg_t[2] ^ ks_r[3];
    kg_lo[1] = kg_t[0] ^ ks_r[4];
    kg_lo[2] = kg_t[1] ^ ks_r[5];
    kg_hi    = ks_r[2:0];
    wr_half  = (kaddr_r < HALF) ? ks_r[2:0] : ks_r[5:3];
  end

  always_comb begin
    rt = sbc_mix(lo_r, rd_data_r);
    if (dec_r) begin
      rn[0] = rt[1] ^ hi_r[1];
      rn[1] = rt[2] ^ hi_r[2];
      rn[2] = rt[0] ^ hi_r[0];
    end else begin
      rn[0] = rt[0] ^ hi_r[2];
      rn[1] = rt[1] ^ hi_r[0];
      rn[2] = rt[2] ^ hi_r[1];
    end
  end

  always_comb begin
    ks_nxt    = ks_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    dec_nxt   = dec_r;
    kaddr_nxt = kaddr_r;
    first_dec = cmd.load ? in_data.kind : dec_r;
    if (cmd.load) begin
      dec_nxt = in_data.kind;
      lo_nxt  = {in_data.block_word_2, in_data.block_word_1, in_data.block_word_0};
      hi_nxt  = {in_data.block_word_5, in_data.block_word_4, in_data.block_word_3};
    end
    if (cmd.kinit) begin
      ks_nxt    = key_reg_r;
      kaddr_nxt = '0;
    end
    if (cmd.kg_step) begin
      kaddr_nxt = kaddr_r + 1'b1;
      if (kg_idx == HALF) begin
        ks_nxt = {kg_lo, kg_hi};
      end else begin
        ks_nxt = {kg_hi, kg_lo};
      end
    end
    if (cmd.kaddr_first) begin
      kaddr_nxt = first_dec ? RLAST : '0;
    end
    if (cmd.rd_step) begin
      if (dec_r) begin
        kaddr_nxt = (kaddr_r == '0) ? RLAST : (kaddr_r - 1'b1);
      end else begin
        kaddr_nxt = (kaddr_r == RLAST) ? '0 : (kaddr_r + 1'b1);
      end
    end
    if (cmd.round_en) begin
      hi_nxt = lo_r;
      lo_nxt = rn;
    end
  end

  always_ff @(posedge clk) begin
    ks_r    <= ks_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    dec_r   <= dec_nxt;
    kaddr_r <= kaddr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.kg_step) begin
      key_mem[kaddr_r[AW-1:0]] <= wr_half;
    end
    rd_data_r <= key_mem[kaddr_r[AW-1:0]];
  end

  assign out_data.result_word_0 = hi_r[0];
  assign out_data.result_word_1 = hi_r[1];
  assign out_data.result_word_2 = hi_r[2];
  assign out_data.result_word_3 = lo_r[0];
  assign out_data.result_word_4 = lo_r[1];
  assign out_data.result_word_5 = lo_r[2];

endmodule
`default_nettype wire

>>> sv/sea_block_cipher.sv
// Top level of the SEA 192-bit block cipher with an on-chip round key schedule.
//
// A request is taken at a rising edge with start high and busy low; in_data
// carries the operation (kind: 0 encrypt, 1 decrypt) and the six block words.
// busy stays high until the result has been shown. The result appears on
// out_data for exactly one cycle with out_valid high; the receiver cannot stall.
// The master key is written through cfg_we, cfg_index (0 to 5) and cfg_data.
// The first request after reset builds the round key schedule from the key
// registers, one round key per cycle into a ROUNDS-entry memory, before that
// request's rounds; later key writes leave the built schedule unchanged
// until the next reset. A request then fetches the first round key, runs the
// rounds one after another through a single round unit, and then enters a
// result state. A new request can be accepted in the cycle after the strobe.
// Reset clears the controller, the schedule flag and the key registers to
// zero; the round key memory is not cleared.
`default_nettype none
module sea_block_cipher
  import sbc_pkg::*;
#(
  parameter int ROUNDS = 51
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire sbc_in_t              in_data,
  output logic                      out_valid,
  output sbc_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire word_t                cfg_data
);

  sbc_cmd_t cmd;

  sbc_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  sbc_datapath #(
    .ROUNDS(ROUNDS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the SEA 192-bit block cipher with its key schedule.
`default_nettype none
module testbench;
  import sbc_pkg::*;

  localparam int CIPHER_ROUNDS = 51;
  localparam int SWAP_ROUND = (CIPHER_ROUNDS + 1) / 2;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  class cipher_checker;
    word_t key_regs[NUM_KEY_REGS];
    word6_t round_keys[CIPHER_ROUNDS];
    bit schedule_built;
    sbc_out_t pending_blocks[$];
    sbc_out_t last_block;
    int mismatches;
    int results_seen;

    function new();
      foreach (key_regs[j]) key_regs[j] = '0;
      schedule_built = 1'b0;
      last_block = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_key(int idx, word_t val);
      if (idx < NUM_KEY_REGS) key_regs[idx] = val;
    endfunction

    function word3_t round_fn(word3_t x, word3_t k);
      word_t a;
      word_t b;
      word_t c;
      word3_t t;
      a = x[0] + k[0];
      b = x[1] + k[1];
      c = x[2] + k[2];
      a ^= b & c;
      b ^= a & c;
      c ^= a | b;
      t[0] = (a >> 1) | (a << (WORD_BITS - 1));
      t[1] = b;
      t[2] = (c << 1) | (c >> (WORD_BITS - 1));
      return t;
    endfunction

    function void build_round_keys();
      word6_t p;
      word6_t q;
      word3_t cst;
      word3_t t;
      int i;
      for (i = 0; i < NUM_KEY_REGS; i++) round_keys[0][i] = key_regs[i];
      for (i = 1; i < CIPHER_ROUNDS; i++) begin
        p = round_keys[i-1];
        cst = '0;
        cst[0] = word_t'((i <= SWAP_ROUND) ? i : CIPHER_ROUNDS - i);
        t = round_fn(p[2:0], cst);
        q[0] = t[2] ^ p[3];
        q[1] = t[0] ^ p[4];
        q[2] = t[1] ^ p[5];
        q[5:3] = p[2:0];
        if (i == SWAP_ROUND) q = {q[2:0], q[5:3]};
        round_keys[i] = q;
      end
      schedule_built = 1'b1;
    endfunction

    function sbc_out_t cipher_block(sbc_in_t req);
      word3_t lo;
      word3_t hi;
      word3_t k;
      word3_t t;
      sbc_out_t res;
      int i;
      lo = {req.block_word_2, req.block_word_1, req.block_word_0};
      hi = {req.block_word_5, req.block_word_4, req.block_word_3};
      if (req.kind == OP_ENCRYPT) begin
        for (i = 1; i <= CIPHER_ROUNDS; i++) begin
          k = (i <= SWAP_ROUND) ? round_keys[i-1][2:0] : round_keys[i-1][5:3];
          t = round_fn(lo, k);
          hi = {t[2] ^ hi[1], t[1] ^ hi[0], t[0] ^ hi[2]};
          {lo, hi} = {hi, lo};
        end
      end else begin
        for (i = CIPHER_ROUNDS; i >= 1; i--) begin
          k = (i > SWAP_ROUND) ? round_keys[i-1][5:3] : round_keys[i-1][2:0];
          t = round_fn(lo, k) ^ hi;
          hi = {t[0], t[2], t[1]};
          {lo, hi} = {hi, lo};
        end
      end
      res.result_word_0 = hi[0];
      res.result_word_1 = hi[1];
      res.result_word_2 = hi[2];
      res.result_word_3 = lo[0];
      res.result_word_4 = lo[1];
      res.result_word_5 = lo[2];
      return res;
    endfunction

    function void record_request(sbc_in_t req);
      if (!schedule_built) build_round_keys();
      last_block = cipher_block(req);
      pending_blocks.push_back(last_block);
    endfunction

    function void check_result(sbc_out_t got);
      sbc_out_t want;
      word6_t w;
      word6_t g;
      results_seen++;
      if (pending_blocks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_blocks.pop_front();
      w = {want.result_word_5, want.result_word_4, want.result_word_3,
           want.result_word_2, want.result_word_1, want.result_word_0};
      g = {got.result_word_5, got.result_word_4, got.result_word_3,
           got.result_word_2, got.result_word_1, got.result_word_0};
      for (int j = 0; j < 6; j++) begin
        if (w[j] !== g[j]) begin
          mismatches++;
          $display("%0t: result_word_%0d mismatch, expected %h, actual %h",
                   $time, j, w[j], g[j]);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  sbc_in_t in_data;
  logic out_valid;
  sbc_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t cfg_data;

  cipher_checker board;
  int cycle_count = 0;
  int n_encrypt = 0;
  int n_decrypt = 0;
  logic last_kind = OP_ENCRYPT;
  bit calm = 1'b0;

  sea_block_cipher #(.ROUNDS(CIPHER_ROUNDS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic sbc_in_t from_result(sbc_out_t r, logic kind);
    sbc_in_t req;
    req.kind = kind;
    req.block_word_0 = r.result_word_0;
    req.block_word_1 = r.result_word_1;
    req.block_word_2 = r.result_word_2;
    req.block_word_3 = r.result_word_3;
    req.block_word_4 = r.result_word_4;
    req.block_word_5 = r.result_word_5;
    return req;
  endfunction

  task automatic issue(input sbc_in_t req);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    board.record_request(req);
    last_kind = req.kind;
    if (req.kind == OP_ENCRYPT) n_encrypt++;
    else n_decrypt++;
  endtask

  task automatic issue_pair(input word_t left, input word_t right);
    sbc_in_t req;
    req = {OP_ENCRYPT, left, left, left, right, right, right};
    issue(req);
    req.kind = OP_DECRYPT;
    issue(req);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Indexes past the last key register are written too; they must be ignored.
  task automatic program_key(input word6_t key);
    for (int j = 0; j < NUM_KEY_REGS + 2; j++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(j);
      cfg_data <= (j < NUM_KEY_REGS) ? key[j] : word_t'($urandom);
      board.write_key(j, (j < NUM_KEY_REGS) ? key[j] : '0);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    sbc_in_t req;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        req = from_result(board.last_block, ~last_kind);
      end else begin
        req = {logic'($urandom_range(0, 1)), pick_word(), pick_word(), pick_word(),
               pick_word(), pick_word(), pick_word()};
      end
      issue(req);
    end
  endtask

  initial begin
    word6_t key;
    board = new();
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first request after reset builds the schedule from this key.
    for (int j = 0; j < 6; j++) key[j] = word_t'($urandom);
    program_key(key);
    issue_pair('0, '0);
    issue_pair('1, '1);
    issue_pair(32'hAAAA_AAAA, 32'h5555_5555);
    issue_pair(32'h8000_0000, 32'h8000_0000);
    issue_pair(32'h0000_0001, 32'h0000_0001);
    issue_pair('1, '0);
    issue_pair(32'h7FFF_FFFF, 32'hFFFF_FFFE);
    for (int r = 0; r < 2; r++) begin
      issue({OP_ENCRYPT, pick_word(), pick_word(), pick_word(),
             pick_word(), pick_word(), pick_word()});
      issue(from_result(board.last_block, OP_DECRYPT));
    end
    calm = 1'b1;
    random_phase(ITEMS_PER_PHASE);
    drain();

    // Later key writes must leave the built schedule untouched.
    program_key('1);
    random_phase(ITEMS_PER_PHASE);
    drain();
    program_key('0);
    random_phase(ITEMS_PER_PHASE / 2);
    drain();
    for (int j = 0; j < 6; j++) key[j] = word_t'($urandom);
    program_key(key);
    random_phase(ITEMS_PER_PHASE / 2);
    drain();
    repeat (CIPHER_ROUNDS + 10) @(posedge clk);

    $display("Checked %0d results from %0d encrypt and %0d decrypt requests.",
             board.results_seen, n_encrypt, n_decrypt);
    $display("Key rewrites after the schedule was built, including unused indexes, were covered.");
    if (board.mismatches == 0 && board.pending_blocks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
